### rtl/core/cps_pkg.sv
`default_nettype none

package cps_pkg;

  // Default build: three refinement stages of Q16.16 coordinates.
  localparam int MAX_LEVELS_DEF  = 3;
  localparam int COORD_WIDTH_DEF = 32;

  // Level register value after reset.
  localparam logic [1:0] LEVELS_RESET = 2'd1;

  // Per-stage history: how many points of the current path a stage has seen.
  typedef logic [1:0] seen_t;
  localparam seen_t SEEN_NONE = 2'd0;
  localparam seen_t SEEN_ONE  = 2'd1;
  localparam seen_t SEEN_MANY = 2'd2;

  // What one lane makes of its (previous, current) pair.
  typedef enum logic [1:0] {
    OP_PASS,      // first point of a path: forward it
    OP_MID,       // first segment: midpoint only
    OP_MID_END,   // last segment: midpoint, then the final point
    OP_QUARTER    // inner segment: 3/4-1/4 and 1/4-3/4 points
  } lane_op_t;

  // Control that travels with a point list from stage to stage.
  typedef struct packed {
    logic valid;
    logic err;
    logic path_end;
  } item_ctl_t;

endpackage

`default_nettype wire

### rtl/core/cps_lane.sv
`default_nettype none

module cps_lane import cps_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic [2:0][COORD_WIDTH-1:0] prev,
  input  logic [2:0][COORD_WIDTH-1:0] cur,
  input  lane_op_t                    op,
  output logic [2:0][COORD_WIDTH-1:0] pt0,
  output logic [2:0][COORD_WIDTH-1:0] pt1
);

  // Two guard bits hold 3a + b exactly.
  localparam int SW = COORD_WIDTH + 2;

  logic signed [SW-1:0]      pa     [3];
  logic signed [SW-1:0]      pc     [3];
  logic signed [SW-1:0]      s_mid  [3];
  logic signed [SW-1:0]      s_near [3];
  logic signed [SW-1:0]      s_far  [3];
  logic [COORD_WIDTH-1:0]    mid    [3];
  logic [COORD_WIDTH-1:0]    near   [3];
  logic [COORD_WIDTH-1:0]    far    [3];

  // Arithmetic right shift of the exact sum gives the floor.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pa[c]     = SW'($signed(prev[c]));
      pc[c]     = SW'($signed(cur[c]));
      s_mid[c]  = pa[c] + pc[c];
      s_near[c] = (pa[c] <<< 1) + pa[c] + pc[c];
      s_far[c]  = pa[c] + (pc[c] <<< 1) + pc[c];
      mid[c]    = COORD_WIDTH'(s_mid[c] >>> 1);
      near[c]   = COORD_WIDTH'(s_near[c] >>> 2);
      far[c]    = COORD_WIDTH'(s_far[c] >>> 2);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (op) inside
        OP_PASS: begin
          pt0[c] = cur[c];
          pt1[c] = cur[c];
        end
        OP_MID, OP_MID_END: begin
          pt0[c] = mid[c];
          pt1[c] = cur[c];
        end
        default: begin
          pt0[c] = near[c];
          pt1[c] = far[c];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/cps_stage.sv
`default_nettype none

module cps_stage import cps_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int STAGE_IDX   = 0
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          clear,
  input  logic                                          enable,
  input  item_ctl_t                                     in_ctl,
  input  logic [MAX_LEVELS:0]                           in_cnt,
  input  logic [2**MAX_LEVELS-1:0][2:0][COORD_WIDTH-1:0] in_pts,
  output logic                                          in_ready,
  output item_ctl_t                                     out_ctl,
  output logic [MAX_LEVELS:0]                           out_cnt,
  output logic [2**MAX_LEVELS-1:0][2:0][COORD_WIDTH-1:0] out_pts,
  input  logic                                          out_ready
);

  localparam int PT_CAP = 2 ** MAX_LEVELS;
  localparam int CNT_W  = MAX_LEVELS + 1;
  localparam int LANES  = 2 ** STAGE_IDX;
  localparam int SLOTS  = 2 * LANES;

  typedef logic [2:0][COORD_WIDTH-1:0] point_t;

  seen_t                         seen;
  point_t                        held;
  seen_t                         lane_seen [LANES];
  point_t                        lane_prev [LANES];
  point_t                        lane_p0   [LANES];
  point_t                        lane_p1   [LANES];
  lane_op_t                      lane_op   [LANES];
  logic                          lane_act  [LANES];
  logic                          lane_end  [LANES];
  logic                          lane_two  [LANES];
  logic [CNT_W-1:0]              lane_off  [LANES];
  logic [CNT_W-1:0]              n_short;
  logic [PT_CAP-1:0][2:0][COORD_WIDTH-1:0] merged;
  logic [CNT_W-1:0]              merged_cnt;
  seen_t                         last_seen;
  point_t                        last_pt;
  logic                          err_now;
  logic                          advance;
  item_ctl_t                     ctl_next;
  logic [CNT_W-1:0]              cnt_next;
  logic [PT_CAP-1:0][2:0][COORD_WIDTH-1:0] pts_next;
  seen_t                         seen_next;
  point_t                        held_next;

  assign in_ready = !out_ctl.valid || out_ready;
  assign advance  = in_ctl.valid && in_ready;

  // Lane i pairs point i with point i-1 (lane 0 with the held point) and
  // sees the history the stage would have after the points before it.
  always_comb begin
    lane_seen[0] = seen;
    lane_prev[0] = held;
    for (int i = 1; i < LANES; i++) begin
      lane_seen[i] = (lane_seen[i-1] == SEEN_NONE) ? SEEN_ONE : SEEN_MANY;
      lane_prev[i] = in_pts[i-1];
    end
    for (int i = 0; i < LANES; i++) begin
      lane_act[i] = CNT_W'(i) < in_cnt;
      lane_end[i] = in_ctl.path_end && (CNT_W'(i + 1) == in_cnt);
      if (lane_seen[i] == SEEN_NONE) begin
        lane_op[i] = OP_PASS;
      end else if (lane_seen[i] == SEEN_ONE || lane_end[i]) begin
        lane_op[i] = lane_end[i] ? OP_MID_END : OP_MID;
      end else begin
        lane_op[i] = OP_QUARTER;
      end
      lane_two[i] = (lane_op[i] == OP_MID_END) || (lane_op[i] == OP_QUARTER);
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cps_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .prev(lane_prev[g]),
      .cur (in_pts[g]),
      .op  (lane_op[g]),
      .pt0 (lane_p0[g]),
      .pt1 (lane_p1[g])
    );
  end

  // Only lanes 0 and 1 can yield a single point; every later lane yields two.
  always_comb begin
    n_short = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_off[i] = CNT_W'(2 * i) - n_short;
      if (i < 2) begin
        n_short = n_short + CNT_W'(!lane_two[i]);
      end
    end
  end

  // Merge: pack the lane outputs into one ordered list.
  always_comb begin
    merged     = '0;
    merged_cnt = CNT_W'(1);
    last_seen  = seen;
    last_pt    = held;
    for (int j = 0; j < SLOTS; j++) begin
      for (int i = 0; i < LANES; i++) begin
        if (lane_act[i] && lane_off[i] == CNT_W'(j)) begin
          merged[j] = lane_p0[i];
        end
        if (lane_act[i] && lane_two[i] && (lane_off[i] + CNT_W'(1)) == CNT_W'(j)) begin
          merged[j] = lane_p1[i];
        end
      end
    end
    for (int i = 0; i < LANES; i++) begin
      if (CNT_W'(i + 1) == in_cnt) begin
        merged_cnt = lane_off[i] + (lane_two[i] ? CNT_W'(2) : CNT_W'(1));
        last_seen  = lane_seen[i];
        last_pt    = in_pts[i];
      end
    end
  end

  always_comb begin
    err_now   = (lane_seen[0] == SEEN_NONE) && lane_end[0];
    ctl_next  = in_ctl;
    cnt_next  = in_cnt;
    pts_next  = in_pts;
    seen_next = seen;
    held_next = held;
    if (in_ctl.err) begin
      // Error from upstream: drop the path here too.
      seen_next = SEEN_NONE;
    end else if (enable) begin
      if (err_now) begin
        ctl_next.err      = 1'b1;
        ctl_next.path_end = 1'b1;
        cnt_next          = CNT_W'(1);
        seen_next         = SEEN_NONE;
      end else begin
        cnt_next  = merged_cnt;
        pts_next  = merged;
        held_next = last_pt;
        if (in_ctl.path_end) begin
          seen_next = SEEN_NONE;
        end else begin
          seen_next = (last_seen == SEEN_NONE) ? SEEN_ONE : SEEN_MANY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
      seen    <= SEEN_NONE;
      held    <= '0;
    end else begin
      if (in_ready) begin
        out_ctl <= ctl_next;
      end
      if (clear) begin
        seen <= SEEN_NONE;
      end else if (advance) begin
        seen <= seen_next;
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cnt <= cnt_next;
      out_pts <= pts_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cps_serializer.sv
`default_nettype none

module cps_serializer import cps_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  item_ctl_t                                     in_ctl,
  input  logic [MAX_LEVELS:0]                           in_cnt,
  input  logic [2**MAX_LEVELS-1:0][2:0][COORD_WIDTH-1:0] in_pts,
  output logic                                          in_ready,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [COORD_WIDTH-1:0]                        out_x,
  output logic [COORD_WIDTH-1:0]                        out_y,
  output logic [COORD_WIDTH-1:0]                        out_z,
  output logic                                          run_last,
  output logic                                          curve_done,
  output logic                                          too_short
);

  localparam int PT_CAP = 2 ** MAX_LEVELS;
  localparam int CNT_W  = MAX_LEVELS + 1;

  logic                                    busy;
  logic [MAX_LEVELS-1:0]                   idx;
  logic [CNT_W-1:0]                        cnt;
  logic                                    err;
  logic                                    path_end;
  logic [PT_CAP-1:0][2:0][COORD_WIDTH-1:0] pts;
  logic [2:0][COORD_WIDTH-1:0]             sel;
  logic                                    last;

  assign last      = ({1'b0, idx} + CNT_W'(1)) == cnt;
  assign sel       = pts[idx];
  assign out_valid = busy;
  assign out_x     = err ? '0 : sel[0];
  assign out_y     = err ? '0 : sel[1];
  assign out_z     = err ? '0 : sel[2];
  assign run_last  = last;
  assign curve_done = last && (err || path_end);
  assign too_short = err;

  // Take the next list while the last point of this one transfers.
  assign in_ready = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_ready) begin
      busy <= in_ctl.valid;
      idx  <= '0;
    end else if (out_ready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ctl.valid) begin
      cnt      <= in_cnt;
      err      <= in_ctl.err;
      path_end <= in_ctl.path_end;
      pts      <= in_pts;
    end
  end

endmodule

`default_nettype wire

### rtl/core/chaikin_polyline_subdivider.sv
// Output: an input yields N results, at most 2**L for L applied levels (8 at three); the single output
//   port hands out one point per cycle while out_ready is high, and each stage holds one list.
// Reset: synchronous rst empties the pipeline, clears every stage's path history
//   and sets levels to 1. No clearing pass; the block takes input right after reset.
`default_nettype none

module chaikin_polyline_subdivider import cps_pkg::*; #(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] x,
  input  logic [COORD_WIDTH-1:0] y,
  input  logic [COORD_WIDTH-1:0] z,
  input  logic                   path_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_x,
  output logic [COORD_WIDTH-1:0] out_y,
  output logic [COORD_WIDTH-1:0] out_z,
  output logic                   run_last,
  output logic                   curve_done,
  output logic                   too_short
);

  localparam int PT_CAP = 2 ** MAX_LEVELS;
  localparam int CNT_W  = MAX_LEVELS + 1;

  // Level register: 0 acts as 1, values above MAX_LEVELS saturate.
  logic [1:0]            levels;
  logic [MAX_LEVELS-1:0] stage_on;

  // Point-list bus between stages: entry 0 is the input point, entry l+1
  // the registered output of stage l, the last entry feeds the serializer.
  item_ctl_t                               bus_ctl   [MAX_LEVELS+1];
  logic [CNT_W-1:0]                        bus_cnt   [MAX_LEVELS+1];
  logic [PT_CAP-1:0][2:0][COORD_WIDTH-1:0] bus_pts   [MAX_LEVELS+1];
  logic                                    bus_ready [MAX_LEVELS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= LEVELS_RESET;
    end else if (cfg_we) begin
      levels <= cfg_wdata;
    end
  end

  // Stage 0 always refines; stage l only while l is below the level count.
  // Stages that are off forward their list unchanged and keep their history.
  always_comb begin
    for (int l = 0; l < MAX_LEVELS; l++) begin
      stage_on[l] = (l == 0) || (l < int'(levels));
    end
  end

  // One input point enters as a list of length one.
  always_comb begin
    bus_ctl[0].valid    = in_valid;
    bus_ctl[0].err      = 1'b0;
    bus_ctl[0].path_end = path_end;
    bus_cnt[0]          = CNT_W'(1);
    bus_pts[0]          = '0;
    bus_pts[0][0][0]    = x;
    bus_pts[0][0][1]    = y;
    bus_pts[0][0][2]    = z;
  end

  assign in_ready = bus_ready[0];

  // Stage l runs 2**l lanes side by side, one per point of its input list,
  // and merges their one or two points each into the list for stage l+1.
  // A config write clears every stage's history, which abandons the path.
  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_stage
    cps_stage #(
      .COORD_WIDTH(COORD_WIDTH),
      .MAX_LEVELS (MAX_LEVELS),
      .STAGE_IDX  (l)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .clear    (cfg_we),
      .enable   (stage_on[l]),
      .in_ctl   (bus_ctl[l]),
      .in_cnt   (bus_cnt[l]),
      .in_pts   (bus_pts[l]),
      .in_ready (bus_ready[l]),
      .out_ctl  (bus_ctl[l+1]),
      .out_cnt  (bus_cnt[l+1]),
      .out_pts  (bus_pts[l+1]),
      .out_ready(bus_ready[l+1])
    );
  end

  // Hand out the final list one point per transfer; a one-point path arrives
  // here as an error list and leaves as a single zeroed too_short result.
  cps_serializer #(
    .COORD_WIDTH(COORD_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_serializer (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (bus_ctl[MAX_LEVELS]),
    .in_cnt    (bus_cnt[MAX_LEVELS]),
    .in_pts    (bus_pts[MAX_LEVELS]),
    .in_ready  (bus_ready[MAX_LEVELS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .run_last  (run_last),
    .curve_done(curve_done),
    .too_short (too_short)
  );

endmodule

`default_nettype wire

### rtl/core/cps_checker.sv
`default_nettype none

module cps_checker import cps_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_x,
  input logic [COORD_WIDTH-1:0] out_y,
  input logic [COORD_WIDTH-1:0] out_z,
  input logic                   run_last,
  input logic                   curve_done,
  input logic                   too_short
);

  // An error result is the only result of its input and ends the path.
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> run_last && curve_done)
    else $error("too_short result without run_last and curve_done");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("too_short result with nonzero coordinates");

  // The final point of a path is always the last result of its input.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && curve_done |-> run_last)
    else $error("curve_done without run_last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(run_last))
    else $error("stalled result dropped or changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind chaikin_polyline_subdivider cps_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_cps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .run_last  (run_last),
  .curve_done(curve_done),
  .too_short (too_short)
);

`default_nettype wire
